// ===== rtl/scr_pkg.sv =====
// scr_pkg: widths, weights and the linearization table for the srgb contrast ratio block
// no dependencies; imported by srgb_contrast_ratio and scr_checker
package scr_pkg;

    localparam int LUMA_FRAC_BITS  = 16;
    localparam int RATIO_FRAC_BITS = 12;
    localparam int WORK_BITS       = 31;

    // widths
    localparam int LIN_W       = LUMA_FRAC_BITS + 1;      // linear channel, up to 1.0
    localparam int LUMA_W      = LUMA_FRAC_BITS + 1;      // luminance, up to 1.0
    localparam int SUM_W       = LUMA_FRAC_BITS + 14;     // weighted sum, weights total 10000
    localparam int DEN_W       = LUMA_FRAC_BITS + 5;      // 20*y + 1.0, up to 21.0
    localparam int RATIO_W     = RATIO_FRAC_BITS + 5;     // Q5.R ratio, also quotient bits
    localparam int DIVD_W      = DEN_W + RATIO_FRAC_BITS; // dividend n*2^R + d/2
    localparam int RECIP_SHIFT = SUM_W + 14;
    localparam int RECIP_W     = RECIP_SHIFT - 13;
    localparam int PROD_W      = SUM_W + RECIP_W;

    // pipeline: lookup, sum, reciprocal multiply, correction, setup, one stage per quotient bit
    localparam int NUM_STAGES  = 5 + RATIO_W;
    localparam int STG_LUT     = 0;
    localparam int STG_SUM     = 1;
    localparam int STG_MUL     = 2;
    localparam int STG_FIX     = 3;
    localparam int STG_SETUP   = 4;

    // luminance weights, scaled by 10000
    localparam logic [13:0] W_RED   = 14'd2126;
    localparam logic [13:0] W_GREEN = 14'd7152;
    localparam logic [13:0] W_BLUE  = 14'd722;
    localparam logic [13:0] LUMA_DIV  = 14'd10000;
    localparam logic [13:0] LUMA_HALF = 14'd5000;

    // floor(2^shift / 10000): quotient comes out at most one low
    localparam logic [63:0]        RECIP64 = (64'd1 << RECIP_SHIFT) / 64'd10000;
    localparam logic [RECIP_W-1:0] RECIP   = RECIP64[RECIP_W-1:0];

    localparam logic [DEN_W-1:0]   LUMA_ONE  = DEN_W'(1) << LUMA_FRAC_BITS;
    localparam logic [RATIO_W-1:0] RATIO_MIN = RATIO_W'(1) << RATIO_FRAC_BITS;
    localparam logic [RATIO_W-1:0] RATIO_MAX = RATIO_W'(21) << RATIO_FRAC_BITS;

    localparam logic [63:0] WORK_ONE = 64'd1 << WORK_BITS;

    typedef logic [LIN_W-1:0] lin_table_t [256];

    // Q0.31 product rounded to nearest
    function automatic logic [63:0] qmul(input logic [63:0] a, input logic [63:0] b);
        return (a * b + (WORK_ONE >> 1)) >> WORK_BITS;
    endfunction

    function automatic logic [63:0] pow5(input logic [63:0] x);
        logic [63:0] x2;
        logic [63:0] x4;
        x2 = qmul(x, x);
        x4 = qmul(x2, x2);
        return qmul(x4, x);
    endfunction

    // srgb code to linear light, Q0.L
    function automatic logic [LIN_W-1:0] lin_value(input logic [7:0] k);
        logic [63:0] kk;
        logic [63:0] num;
        logic [63:0] t;
        logic [63:0] u;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] mid;
        logic [63:0] y;
        int          i;
        kk = {56'd0, k};
        if (kk <= 64'd10) begin
            num = (kk * 64'd100) << LUMA_FRAC_BITS;
            return LIN_W'((num + 64'd164730) / 64'd329460);
        end
        t = (((64'd1000 * kk + 64'd14025) << WORK_BITS) + 64'd134512) / 64'd269025;
        if (t > WORK_ONE) begin
            t = WORK_ONE;
        end
        u  = qmul(t, t);
        lo = 64'd0;
        hi = WORK_ONE;
        // fifth root of t^2 by bisection, so that t^2.4 = t^2 * t^0.4
        for (i = 0; i < 40; i++) begin
            if (lo < hi) begin
                mid = lo + ((hi - lo + 64'd1) >> 1);
                if (pow5(mid) <= u) begin
                    lo = mid;
                end else begin
                    hi = mid - 64'd1;
                end
            end
        end
        y = qmul(u, lo);
        return LIN_W'((y + (64'd1 << (WORK_BITS - LUMA_FRAC_BITS - 1)))
                      >> (WORK_BITS - LUMA_FRAC_BITS));
    endfunction

    function automatic lin_table_t build_lin_table();
        lin_table_t tbl;
        int         k;
        for (k = 0; k < 256; k++) begin
            tbl[k] = lin_value(8'(k));
        end
        return tbl;
    endfunction

    localparam lin_table_t LIN_TABLE = build_lin_table();

endpackage

// ===== rtl/srgb_contrast_ratio.sv =====
// srgb_contrast_ratio: contrast ratio of two 8-bit srgb colors, unsigned Q5.12
// depends on scr_pkg for widths, weights and the linearization table
//
//  channel | ports                         | beat
//  --------+-------------------------------+-------------------------------------
//  input   | s_valid s_ready s_fg_* s_bg_* | one foreground/background color pair
//  result  | m_valid m_ready m_ratio       | one contrast ratio, 1.0 to 21.0
//
// one beat per cycle in, one out, while the output is not stalled
// stages: table lookup, weighted sums, reciprocal multiply, rounding fix,
//   ratio setup, then one restoring divide step per quotient bit (17)
// reset (aresetn low at a clock edge) clears only the stage valid bits
// a stage loads when it is empty or its successor moves, so a stalled output
//   lets bubbles close up and input keeps flowing until the pipe is full
// s_ready is combinational from m_ready through the per-stage ready chain
module srgb_contrast_ratio
    import scr_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_fg_red,
    input  logic [7:0]         s_fg_green,
    input  logic [7:0]         s_fg_blue,
    input  logic [7:0]         s_bg_red,
    input  logic [7:0]         s_bg_green,
    input  logic [7:0]         s_bg_blue,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [RATIO_W-1:0] m_ratio
);

    // stage valid bits and the ready chain
    logic [NUM_STAGES-1:0] vld_reg;
    logic [NUM_STAGES-1:0] vld_next;
    logic [NUM_STAGES:0]   rdy;

    // lookup stage: fg r,g,b then bg r,g,b
    logic [LIN_W-1:0]  lin_reg [6];
    // weighted sums with the rounding half already added
    logic [SUM_W-1:0]  sum_fg_reg;
    logic [SUM_W-1:0]  sum_bg_reg;
    logic [SUM_W-1:0]  sum_fg_next;
    logic [SUM_W-1:0]  sum_bg_next;
    // reciprocal products, sums kept for the correction
    logic [PROD_W-1:0] prod_fg_reg;
    logic [PROD_W-1:0] prod_bg_reg;
    logic [SUM_W-1:0]  x_fg_reg;
    logic [SUM_W-1:0]  x_bg_reg;
    // luminance after the correction
    logic [LUMA_W-1:0] luma_fg_reg;
    logic [LUMA_W-1:0] luma_bg_reg;
    logic [LUMA_W-1:0] luma_fg_next;
    logic [LUMA_W-1:0] luma_bg_next;
    logic [LUMA_W-1:0] q0_fg;
    logic [LUMA_W-1:0] q0_bg;
    logic [SUM_W-1:0]  rm_fg;
    logic [SUM_W-1:0]  rm_bg;
    // divider: index 0 is setup, index j is after quotient step j
    logic [DEN_W-1:0]   rem_reg [RATIO_W+1];
    logic [RATIO_W-1:0] sh_reg  [RATIO_W+1];
    logic [DEN_W-1:0]   den_reg [RATIO_W+1];
    logic [DEN_W-1:0]   rem_next [RATIO_W+1];
    logic [RATIO_W-1:0] sh_next  [RATIO_W+1];
    logic [DEN_W-1:0]   den_next [RATIO_W+1];
    // setup math
    logic [LUMA_W-1:0] light;
    logic [LUMA_W-1:0] dark;
    logic [DEN_W-1:0]  num_val;
    logic [DEN_W-1:0]  den_val;
    logic [DIVD_W-1:0] dividend;
    logic [DEN_W:0]    cand [RATIO_W+1];
    logic              ge   [RATIO_W+1];

    // a stage may load when empty or when its successor is moving
    always_comb begin
        rdy[NUM_STAGES] = m_ready;
        for (int i = NUM_STAGES - 1; i >= 0; i--) begin
            rdy[i] = !vld_reg[i] || rdy[i+1];
        end
    end

    assign s_ready = rdy[0];
    assign m_valid = vld_reg[NUM_STAGES-1];
    assign m_ratio = sh_reg[RATIO_W];

    always_comb begin
        vld_next = vld_reg;
        if (rdy[0]) begin
            vld_next[0] = s_valid;
        end
        for (int i = 1; i < NUM_STAGES; i++) begin
            if (rdy[i]) begin
                vld_next[i] = vld_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    // weighted sums, exact in SUM_W bits
    always_comb begin
        sum_fg_next = SUM_W'(lin_reg[0]) * SUM_W'(W_RED)
                    + SUM_W'(lin_reg[1]) * SUM_W'(W_GREEN)
                    + SUM_W'(lin_reg[2]) * SUM_W'(W_BLUE)
                    + SUM_W'(LUMA_HALF);
        sum_bg_next = SUM_W'(lin_reg[3]) * SUM_W'(W_RED)
                    + SUM_W'(lin_reg[4]) * SUM_W'(W_GREEN)
                    + SUM_W'(lin_reg[5]) * SUM_W'(W_BLUE)
                    + SUM_W'(LUMA_HALF);
    end

    // divide by 10000: the reciprocal quotient is exact or one low
    always_comb begin
        q0_fg = prod_fg_reg[RECIP_SHIFT +: LUMA_W];
        q0_bg = prod_bg_reg[RECIP_SHIFT +: LUMA_W];
        rm_fg = x_fg_reg - SUM_W'(q0_fg) * SUM_W'(LUMA_DIV);
        rm_bg = x_bg_reg - SUM_W'(q0_bg) * SUM_W'(LUMA_DIV);
        luma_fg_next = q0_fg + LUMA_W'(rm_fg >= SUM_W'(LUMA_DIV));
        luma_bg_next = q0_bg + LUMA_W'(rm_bg >= SUM_W'(LUMA_DIV));
    end

    // ratio setup: n = 20*light + 1.0, d = 20*dark + 1.0, dividend n*2^R + d/2
    always_comb begin
        light    = (luma_fg_reg > luma_bg_reg) ? luma_fg_reg : luma_bg_reg;
        dark     = (luma_fg_reg > luma_bg_reg) ? luma_bg_reg : luma_fg_reg;
        num_val  = (DEN_W'(light) << 4) + (DEN_W'(light) << 2) + LUMA_ONE;
        den_val  = (DEN_W'(dark) << 4) + (DEN_W'(dark) << 2) + LUMA_ONE;
        dividend = (DIVD_W'(num_val) << RATIO_FRAC_BITS) + DIVD_W'(den_val >> 1);
        // top bits are below 1.0 in Q0.L, so below d
        rem_next[0] = DEN_W'(dividend[DIVD_W-1:RATIO_W]);
        sh_next[0]  = dividend[RATIO_W-1:0];
        den_next[0] = den_val;
        cand[0]     = '0;
        ge[0]       = 1'b0;
        // restoring steps: dividend bits shift out the top, quotient bits in at the bottom
        for (int j = 1; j <= RATIO_W; j++) begin
            cand[j] = {rem_reg[j-1], sh_reg[j-1][RATIO_W-1]};
            ge[j]   = cand[j] >= {1'b0, den_reg[j-1]};
            if (ge[j]) begin
                rem_next[j] = DEN_W'(cand[j] - {1'b0, den_reg[j-1]});
            end else begin
                rem_next[j] = cand[j][DEN_W-1:0];
            end
            sh_next[j]  = {sh_reg[j-1][RATIO_W-2:0], ge[j]};
            den_next[j] = den_reg[j-1];
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        if (rdy[STG_LUT]) begin
            lin_reg[0] <= LIN_TABLE[s_fg_red];
            lin_reg[1] <= LIN_TABLE[s_fg_green];
            lin_reg[2] <= LIN_TABLE[s_fg_blue];
            lin_reg[3] <= LIN_TABLE[s_bg_red];
            lin_reg[4] <= LIN_TABLE[s_bg_green];
            lin_reg[5] <= LIN_TABLE[s_bg_blue];
        end
        if (rdy[STG_SUM]) begin
            sum_fg_reg <= sum_fg_next;
            sum_bg_reg <= sum_bg_next;
        end
        if (rdy[STG_MUL]) begin
            prod_fg_reg <= PROD_W'(sum_fg_reg) * PROD_W'(RECIP);
            prod_bg_reg <= PROD_W'(sum_bg_reg) * PROD_W'(RECIP);
            x_fg_reg    <= sum_fg_reg;
            x_bg_reg    <= sum_bg_reg;
        end
        if (rdy[STG_FIX]) begin
            luma_fg_reg <= luma_fg_next;
            luma_bg_reg <= luma_bg_next;
        end
        for (int j = 0; j <= RATIO_W; j++) begin
            if (rdy[STG_SETUP + j]) begin
                rem_reg[j] <= rem_next[j];
                sh_reg[j]  <= sh_next[j];
                den_reg[j] <= den_next[j];
            end
        end
    end

endmodule

// ===== rtl/scr_checker.sv =====
// scr_checker: port-level checks on srgb_contrast_ratio, attached by bind
// depends on scr_pkg for the ratio width and range
module scr_checker
    import scr_pkg::*;
(
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input logic [RATIO_W-1:0] m_ratio
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_ratio))
        else $error("result beat changed while stalled");

    // every ratio lies between 1.0 and 21.0
    a_ratio_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_ratio >= RATIO_MIN) && (m_ratio <= RATIO_MAX))
        else $error("ratio out of range");

    // an empty or draining output stage never blocks the input
    a_ready_flow: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_ready || !m_valid) |-> s_ready)
        else $error("input blocked while output moves");

    // reset empties the pipe
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind srgb_contrast_ratio scr_checker u_scr_checker (.*);

// ===== verif/srgb_contrast_ratio_tb.sv =====
// srgb_contrast_ratio_tb: self-checking bench for the srgb contrast ratio pipeline
// depends on scr_pkg for port widths and the pipeline depth; predicts every ratio itself
// directed color pairs, a back-pressure fill and a long random stream, both sides idling
module srgb_contrast_ratio_tb;
    import scr_pkg::*;

    localparam int          HALF_PERIOD  = 10;
    localparam int          RESET_CYCLES = 4;
    localparam int          PIPE_DEPTH   = NUM_STAGES;
    localparam int          STALL_LIMIT  = 2000;   // cycles with no beat on either side
    localparam int          HOLD_CYCLES  = 120;    // long receiver hold-off
    localparam int          IDLE_PCT     = 28;
    localparam int          RANDOM_PAIRS = 350;
    localparam int          FILL_PAIRS   = 50;

    // fixed-point constants of the luminance math
    localparam int          Q31_BITS     = 31;
    localparam logic [63:0] UNIT_Q31     = 64'd1 << Q31_BITS;
    localparam logic [63:0] KNEE_CODE    = 64'd10;        // last code on the linear segment
    localparam logic [63:0] LINEAR_DIV   = 64'd329460;    // 255 * 12.92 * 100
    localparam logic [63:0] POWER_DIV    = 64'd269025;    // 255 * 1.055 * 1000
    localparam logic [63:0] POWER_OFFSET = 64'd14025;     // 0.055 * 255 * 1000
    localparam logic [63:0] WEIGHT_RED   = 64'd2126;
    localparam logic [63:0] WEIGHT_GREEN = 64'd7152;
    localparam logic [63:0] WEIGHT_BLUE  = 64'd722;
    localparam logic [63:0] WEIGHT_TOTAL = 64'd10000;

    localparam logic [23:0] BLACK = 24'h000000;
    localparam logic [23:0] WHITE = 24'hFFFFFF;

    typedef struct {
        logic [23:0]        fg;
        logic [23:0]        bg;
        logic [RATIO_W-1:0] ratio;
    } ratio_expect_t;

    // dut ports, all inputs known from time zero
    logic               aclk       = 1'b0;
    logic               aresetn    = 1'b0;
    logic               s_valid    = 1'b0;
    logic               s_ready;
    logic [7:0]         s_fg_red   = 8'd0;
    logic [7:0]         s_fg_green = 8'd0;
    logic [7:0]         s_fg_blue  = 8'd0;
    logic [7:0]         s_bg_red   = 8'd0;
    logic [7:0]         s_bg_green = 8'd0;
    logic [7:0]         s_bg_blue  = 8'd0;
    logic               m_valid;
    logic               m_ready    = 1'b0;
    logic [RATIO_W-1:0] m_ratio;

    // linear light per srgb code, Q0.L, filled once before reset is released
    logic [LIN_W-1:0]   linear_of_code [256];

    ratio_expect_t      expected_ratios [$];
    ratio_expect_t      oldest_ratio;
    int                 error_count   = 0;
    int                 pairs_sent    = 0;
    int                 ratios_seen   = 0;
    int                 idle_cycles   = 0;
    int                 hold_left     = 0;
    bit                 hold_request  = 1'b0;  // asks the receiver for one long hold-off
    bit                 no_idle       = 1'b0;  // both sides run flat out while set

    srgb_contrast_ratio dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_fg_red   (s_fg_red),
        .s_fg_green (s_fg_green),
        .s_fg_blue  (s_fg_blue),
        .s_bg_red   (s_bg_red),
        .s_bg_green (s_bg_green),
        .s_bg_blue  (s_bg_blue),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_ratio    (m_ratio)
    );

    always begin
        #HALF_PERIOD aclk = 1'b1;
        #HALF_PERIOD aclk = 1'b0;
    end

    // ---------------------------------------------------------------- prediction

    // Q0.31 product, rounded to nearest
    function automatic logic [63:0] q31_mul(input logic [63:0] a, input logic [63:0] b);
        return (a * b + (UNIT_Q31 >> 1)) >> Q31_BITS;
    endfunction

    // fifth power as a chain of rounded products: x^2, x^4, x^5
    function automatic logic [63:0] q31_pow5(input logic [63:0] x);
        logic [63:0] sq;
        logic [63:0] quad;
        sq   = q31_mul(x, x);
        quad = q31_mul(sq, sq);
        return q31_mul(quad, x);
    endfunction

    // srgb code to linear light in Q0.L
    function automatic logic [LIN_W-1:0] srgb_to_linear(input logic [7:0] code);
        logic [63:0] k;
        logic [63:0] t;
        logic [63:0] t_sq;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] mid;
        logic [63:0] y;
        int          shift;
        k     = 64'(code);
        shift = Q31_BITS - LUMA_FRAC_BITS;
        // dark codes sit on the straight segment k / (255 * 12.92)
        if (k <= KNEE_CODE) begin
            return LIN_W'((((k * 64'd100) << LUMA_FRAC_BITS) + LINEAR_DIV / 2) / LINEAR_DIV);
        end
        // t = (k/255 + 0.055) / 1.055 in Q0.31, capped at one
        t = (((64'd1000 * k + POWER_OFFSET) << Q31_BITS) + POWER_DIV / 2) / POWER_DIV;
        if (t > UNIT_Q31) begin
            t = UNIT_Q31;
        end
        // t^2.4 = t^2 * fifth root of t^2, root by bisection on the rounded power
        t_sq = q31_mul(t, t);
        lo   = 64'd0;
        hi   = UNIT_Q31;
        while (lo < hi) begin
            mid = lo + ((hi - lo + 64'd1) >> 1);
            if (q31_pow5(mid) <= t_sq) begin
                lo = mid;
            end else begin
                hi = mid - 64'd1;
            end
        end
        y = q31_mul(t_sq, lo);
        return LIN_W'((y + (64'd1 << (shift - 1))) >> shift);
    endfunction

    // weighted sum of the three channels, rounded back to Q0.L
    function automatic logic [63:0] rel_luminance(input logic [23:0] rgb);
        logic [63:0] acc;
        acc = WEIGHT_RED   * 64'(linear_of_code[rgb[23:16]])
            + WEIGHT_GREEN * 64'(linear_of_code[rgb[15:8]])
            + WEIGHT_BLUE  * 64'(linear_of_code[rgb[7:0]]);
        return (acc + WEIGHT_TOTAL / 2) / WEIGHT_TOTAL;
    endfunction

    // (lighter + 0.05) / (darker + 0.05), both sides scaled by 20 so the offset is exact
    function automatic logic [RATIO_W-1:0] predict_ratio(input logic [23:0] fg,
                                                         input logic [23:0] bg);
        logic [63:0] y_fg;
        logic [63:0] y_bg;
        logic [63:0] lighter;
        logic [63:0] darker;
        logic [63:0] num;
        logic [63:0] den;
        y_fg    = rel_luminance(fg);
        y_bg    = rel_luminance(bg);
        lighter = (y_fg > y_bg) ? y_fg : y_bg;
        darker  = (y_fg > y_bg) ? y_bg : y_fg;
        num     = 64'd20 * lighter + (64'd1 << LUMA_FRAC_BITS);
        den     = 64'd20 * darker  + (64'd1 << LUMA_FRAC_BITS);
        return RATIO_W'(((num << RATIO_FRAC_BITS) + den / 2) / den);
    endfunction

    // ---------------------------------------------------------------- result side

    // receiver: random stalls, a flat-out mode, and one long hold-off on request
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            m_ready   <= 1'b0;
            hold_left  = hold_left - 1;
        end else if (hold_request) begin
            m_ready      <= 1'b0;
            hold_left     = HOLD_CYCLES - 1;
            hold_request  = 1'b0;
        end else if (no_idle) begin
            m_ready <= 1'b1;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // every result beat is matched against the oldest prediction
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            ratios_seen++;
            if (expected_ratios.size() == 0) begin
                error_count++;
                $display("%0t: unexpected ratio beat, expected none, actual %0d",
                         $time, m_ratio);
            end else begin
                oldest_ratio = expected_ratios.pop_front();
                if (m_ratio !== oldest_ratio.ratio) begin
                    error_count++;
                    $display("%0t: ratio mismatch fg %06h bg %06h, expected %0d, actual %0d",
                             $time, oldest_ratio.fg, oldest_ratio.bg,
                             oldest_ratio.ratio, m_ratio);
                end
            end
        end
    end

    // watchdog: ends the run once no beat has moved for too long
    initial begin
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge aclk);
            if (aresetn) begin
                if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                    idle_cycles = 0;
                end else begin
                    idle_cycles++;
                end
            end
        end
        $display("%0t: no beat for %0d cycles, %0d ratios still pending",
                 $time, STALL_LIMIT, expected_ratios.size());
        $display("srgb_contrast_ratio test failed");
        $finish;
    end

    // ---------------------------------------------------------------- input side

    // offers one color pair, maybe after idle cycles, and returns at the edge it is taken;
    // valid stays high on return so back-to-back pairs need no second assignment
    task automatic send_pair(input logic [23:0] fg, input logic [23:0] bg);
        ratio_expect_t entry;
        while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_fg_red   <= fg[23:16];
        s_fg_green <= fg[15:8];
        s_fg_blue  <= fg[7:0];
        s_bg_red   <= bg[23:16];
        s_bg_green <= bg[15:8];
        s_bg_blue  <= bg[7:0];
        do begin
            @(posedge aclk);
        end while (!(s_valid && s_ready));
        entry.fg    = fg;
        entry.bg    = bg;
        entry.ratio = predict_ratio(fg, bg);
        expected_ratios = {expected_ratios, entry};
        pairs_sent++;
    endtask

    // sender pauses until every predicted ratio has come out
    task automatic drain_ratios();
        s_valid <= 1'b0;
        while (expected_ratios.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    function automatic logic [23:0] gray(input logic [7:0] level);
        return {level, level, level};
    endfunction

    // ---------------------------------------------------------------- tests

    // black against white both ways, equal extremes, primaries against black, magenta against green
    task automatic test_extremes();
        send_pair(WHITE, BLACK);        // the 21:1 maximum
        send_pair(BLACK, WHITE);        // same with foreground and background swapped
        send_pair(WHITE, WHITE);        // equal colors give exactly 1.0
        send_pair(BLACK, BLACK);
        send_pair(24'hFF0000, BLACK);
        send_pair(24'h00FF00, BLACK);
        send_pair(BLACK, 24'h0000FF);
        send_pair(24'hFF00FF, 24'h00FF00);
    endtask

    // codes on either side of the linear/power knee
    task automatic test_knee_codes();
        send_pair(gray(8'd10), BLACK);
        send_pair(gray(8'd11), BLACK);
        send_pair(gray(8'd10), gray(8'd11));
        send_pair(24'h0A0B0C, 24'h0C0B0A);
    endtask

    // equal non-extreme colors and swapped pairs
    task automatic test_equal_and_swapped();
        send_pair(gray(8'h80), gray(8'h80));
        send_pair(24'h123456, 24'hFEDCBA);
        send_pair(24'hFEDCBA, 24'h123456);
        send_pair(gray(8'h77), WHITE);  // close to the 4.5 threshold
        send_pair(WHITE, gray(8'h77));
    endtask

    // receiver holds off long enough for the pipe to fill and push back on the input
    task automatic test_backpressure_fill();
        int i;
        no_idle      = 1'b1;
        hold_request = 1'b1;
        for (i = 0; i < FILL_PAIRS; i++) begin
            send_pair(24'($urandom), 24'($urandom));
        end
        no_idle = 1'b0;
    endtask

    // mostly uniform colors, with equal pairs, grays, knee codes, extremes and swaps
    task automatic test_random_stream(input int count);
        int          i;
        logic [23:0] fg;
        logic [23:0] bg;
        for (i = 0; i < count; i++) begin
            // a long stretch in the middle with no idling on either side
            no_idle = (i >= count / 3) && (i < count / 3 + 120);
            fg = 24'($urandom);
            bg = 24'($urandom);
            case ($urandom_range(0, 9))
                0: begin
                    bg = fg;
                end
                1: begin
                    fg = gray(8'($urandom));
                    bg = gray(8'($urandom));
                end
                2: begin
                    fg = {8'($urandom_range(8, 13)), 8'($urandom_range(8, 13)),
                          8'($urandom_range(8, 13))};
                    bg = {8'($urandom_range(0, 13)), 8'($urandom_range(0, 13)),
                          8'($urandom_range(0, 13))};
                end
                3: begin
                    fg = {{8{fg[0]}}, {8{fg[1]}}, {8{fg[2]}}};
                    bg = {{8{bg[0]}}, {8{bg[1]}}, {8{bg[2]}}};
                end
                4: begin
                    send_pair(bg, fg);  // the swapped twin goes first
                end
                default: begin
                end
            endcase
            send_pair(fg, bg);
        end
        no_idle = 1'b0;
    endtask

    // ---------------------------------------------------------------- sequence

    initial begin
        int k;
        for (k = 0; k < 256; k++) begin
            linear_of_code[k] = srgb_to_linear(8'(k));
        end
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_extremes();
        drain_ratios();
        test_knee_codes();
        drain_ratios();
        test_equal_and_swapped();
        drain_ratios();
        test_backpressure_fill();
        drain_ratios();
        test_random_stream(RANDOM_PAIRS);
        drain_ratios();

        // let any stray beat show up before the verdict
        repeat (PIPE_DEPTH + 8) @(posedge aclk);

        $display("covered %0d color pairs: extremes, knee codes, equal and swapped pairs,",
                 pairs_sent);
        $display("a full-pipe hold-off and a random stream; %0d ratios checked, %0d errors",
                 ratios_seen, error_count);
        if (error_count == 0 && expected_ratios.size() == 0) begin
            $display("srgb_contrast_ratio test passed");
        end else begin
            $display("srgb_contrast_ratio test failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/scr_pkg.sv
rtl/srgb_contrast_ratio.sv
rtl/scr_checker.sv
verif/srgb_contrast_ratio_tb.sv
